[rtl/harris_corner_detector_defines.svh]
// assertion macros for the harris corner detector
`ifndef HARRIS_CORNER_DETECTOR_DEFINES_SVH
`define HARRIS_CORNER_DETECTOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define HCD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define HCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/hcd_pkg.sv]
// shared constants and types of the harris corner detector
`default_nettype none

package hcd_pkg;

  localparam int GREY_W      = 8;
  localparam int CFG_SIZE_W  = 12;
  localparam int K_W         = 16;
  localparam int FRAC_W      = 16;
  localparam int THR_W       = 63;
  localparam int CFG_DATA_W  = 63;
  localparam int CFG_INDEX_W = 2;
  localparam int GRAD_W      = 11;
  localparam int SQ_W        = 20;
  localparam int CROSS_W     = 21;
  localparam int ROW_W       = 11;
  localparam int MAX_HEIGHT  = 2048;

  localparam logic [CFG_SIZE_W-1:0] WIDTH_RESET     = 12'd640;
  localparam logic [CFG_SIZE_W-1:0] HEIGHT_RESET    = 12'd480;
  localparam logic [K_W-1:0]        K_RESET         = 16'd3932;
  localparam logic [THR_W-1:0]      THRESHOLD_RESET = '0;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IMAGE_WIDTH        = 2'd0,
    REG_IMAGE_HEIGHT       = 2'd1,
    REG_HARRIS_K           = 2'd2,
    REG_RESPONSE_THRESHOLD = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic centre_valid;
    logic in_core;
  } pos_flags_t;

endpackage

`default_nettype wire

[rtl/hcd_stream_if.sv]
// pixel and result stream interfaces
`default_nettype none

interface hcd_pixel_if import hcd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [GREY_W-1:0] pixel;
  logic              start_of_frame;

  modport source(output valid, pixel, start_of_frame, input ready);
  modport sink(input valid, pixel, start_of_frame, output ready);
endinterface

interface hcd_result_if import hcd_pkg::*; ();
  logic valid;
  logic ready;
  logic corner;
  logic centre_valid;

  modport source(output valid, corner, centre_valid, input ready);
  modport sink(input valid, corner, centre_valid, output ready);
endinterface

`default_nettype wire

[rtl/harris_corner_detector.sv]
// streaming harris corner detector, sobel gradients and box window
// usage:
//   pixels: grey pixels in raster order, one transfer per pixel, start_of_frame
//   on the first pixel of an image forces row 0, column 0.
//   results: one transfer per pixel transfer, in order; it flags the centre
//   DELAY rows and columns back (3 for WINDOW 5), centre_valid tells whether
//   that centre lies inside the image.
//   cfg: write image_width, image_height, harris_k, response_threshold by index
//   while no pixel is in flight.
// throughput: one pixel per clock, sustained while results.ready stays high.
// pipeline: ten pipeline stages and the output register lie between a pixel
//   transfer and its result.
// the window sums come from column words that hold WINDOW rows and are
// updated by read-modify-write, one column per pixel.
// reset: clears counters, pipeline valid bits and the registers to defaults;
//   line memories are not cleared.
// stall: when results.ready is low the stages fill up behind the output
//   register, bubbles are squeezed out, then pixels.ready drops.
`default_nettype none
`include "harris_corner_detector_defines.svh"

module harris_corner_detector
  import hcd_pkg::*;
#(
  parameter int MAX_WIDTH = 2048,
  parameter int WINDOW    = 5
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  hcd_pixel_if.sink              pixels,
  hcd_result_if.source           results
);

  localparam int HALF   = WINDOW / 2;
  localparam int SPAN   = 2 * HALF + 1;
  localparam int DELAY  = HALF + 1;
  localparam int CORE   = 2 * DELAY;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int SLOT_W = $clog2(SPAN);
  localparam int SIZE_W = ($clog2(MAX_WIDTH + 1) > CFG_SIZE_W) ?
                          $clog2(MAX_WIDTH + 1) : CFG_SIZE_W;
  localparam int POS_W  = SIZE_W + 1;
  localparam int CS_W   = SQ_W + $clog2(SPAN);
  localparam int WIN_W  = SQ_W + $clog2(SPAN * SPAN);
  localparam int PROD_W = 2 * WIN_W;
  localparam int DET_W  = PROD_W + 1;
  localparam int TR_W   = WIN_W + 1;
  localparam int T2_W   = 2 * TR_W;
  localparam int HI_W   = K_W + T2_W - FRAC_W;
  localparam int KT_W   = HI_W + 1;
  localparam int RESP_W = KT_W + 2;
  localparam int CMP_W  = 64;
  localparam int NS     = 10;

  // configuration
  logic [CFG_SIZE_W-1:0]   image_width;
  logic [CFG_SIZE_W-1:0]   image_height;
  logic [K_W-1:0]          harris_k;
  logic signed [THR_W-1:0] response_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width        <= WIDTH_RESET;
      image_height       <= HEIGHT_RESET;
      harris_k           <= K_RESET;
      response_threshold <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:        image_width        <= cfg_data[CFG_SIZE_W-1:0];
        REG_IMAGE_HEIGHT:       image_height       <= cfg_data[CFG_SIZE_W-1:0];
        REG_HARRIS_K:           harris_k           <= cfg_data[K_W-1:0];
        REG_RESPONSE_THRESHOLD: response_threshold <= cfg_data[THR_W-1:0];
      endcase
    end
  end

  // pipeline handshake
  logic [NS:1]   v;
  logic [NS+1:1] rdy;
  logic [NS:0]   adv;
  logic          out_v;

  always_comb begin
    rdy[NS+1] = !out_v || results.ready;
    for (int i = NS; i >= 1; i--) begin
      rdy[i] = !v[i] || rdy[i+1];
    end
    adv[0] = pixels.valid && rdy[1];
    for (int i = 1; i <= NS; i++) begin
      adv[i] = v[i] && rdy[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[1]) begin
        v[1] <= pixels.valid;
      end
      for (int i = 2; i <= NS; i++) begin
        if (rdy[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  assign pixels.ready = rdy[1];

  // position counters
  logic [COL_W-1:0]  col_count, col_count_next, col_cur;
  logic [ROW_W-1:0]  row_count, row_count_next, row_cur;
  logic [1:0]        row_mod3, row_mod3_next, mod3_cur, up_row, up2_row;
  logic [SLOT_W-1:0] row_slot, row_slot_next, slot_cur, slot_prev;
  logic [SIZE_W-1:0] w_eff, h_eff;
  logic [POS_W-1:0]  col_x, row_x, w_x, h_x;
  logic              col_wrap, row_wrap, centre_ok, inside_ok;

  always_comb begin
    if (image_width == '0) begin
      w_eff = SIZE_W'(1);
    end else if (SIZE_W'(image_width) > SIZE_W'(MAX_WIDTH)) begin
      w_eff = SIZE_W'(MAX_WIDTH);
    end else begin
      w_eff = SIZE_W'(image_width);
    end
    if (image_height == '0) begin
      h_eff = SIZE_W'(1);
    end else if (SIZE_W'(image_height) > SIZE_W'(MAX_HEIGHT)) begin
      h_eff = SIZE_W'(MAX_HEIGHT);
    end else begin
      h_eff = SIZE_W'(image_height);
    end

    col_cur  = pixels.start_of_frame ? '0 : col_count;
    row_cur  = pixels.start_of_frame ? '0 : row_count;
    mod3_cur = pixels.start_of_frame ? '0 : row_mod3;
    slot_cur = pixels.start_of_frame ? '0 : row_slot;

    col_x = POS_W'(col_cur);
    row_x = POS_W'(row_cur);
    w_x   = POS_W'(w_eff);
    h_x   = POS_W'(h_eff);

    centre_ok = row_x >= POS_W'(DELAY) && col_x >= POS_W'(DELAY) &&
                (row_x - POS_W'(DELAY)) < h_x && (col_x - POS_W'(DELAY)) < w_x;
    inside_ok = centre_ok && row_x >= POS_W'(CORE) && col_x >= POS_W'(CORE) &&
                row_x < h_x && col_x < w_x;

    col_wrap = (col_x + POS_W'(1)) >= w_x;
    row_wrap = (row_x + POS_W'(1)) >= h_x;

    up_row    = (mod3_cur == 2'd0) ? 2'd2 : mod3_cur - 2'd1;
    up2_row   = (mod3_cur == 2'd2) ? 2'd0 : mod3_cur + 2'd1;
    slot_prev = (slot_cur == '0) ? SLOT_W'(SPAN - 1) : slot_cur - SLOT_W'(1);

    col_count_next = col_cur + COL_W'(1);
    row_count_next = row_cur;
    row_mod3_next  = mod3_cur;
    row_slot_next  = slot_cur;
    if (col_wrap) begin
      col_count_next = '0;
      if (row_wrap) begin
        row_count_next = '0;
        row_mod3_next  = '0;
        row_slot_next  = '0;
      end else begin
        row_count_next = row_cur + ROW_W'(1);
        row_mod3_next  = (mod3_cur == 2'd2) ? 2'd0 : mod3_cur + 2'd1;
        row_slot_next  = (slot_cur == SLOT_W'(SPAN - 1)) ? '0 : slot_cur + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      row_mod3  <= '0;
      row_slot  <= '0;
    end else if (adv[0]) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
      row_mod3  <= row_mod3_next;
      row_slot  <= row_slot_next;
    end
  end

  // flags that travel with each pixel
  pos_flags_t fl [1:NS];

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      fl[1] <= '{centre_valid: centre_ok, in_core: inside_ok};
    end
    for (int i = 2; i <= NS; i++) begin
      if (adv[i-1]) begin
        fl[i] <= fl[i-1];
      end
    end
  end

  // stage 1: grey line memory, three rows
  logic [GREY_W-1:0] grey_mem [3][MAX_WIDTH];
  logic [GREY_W-1:0] s1_pix, s1_up, s1_up2;
  logic              s1_gen, s1_gnz;
  logic [SLOT_W-1:0] s1_slot;
  logic [COL_W-1:0]  s1_col;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      grey_mem[mod3_cur][col_cur] <= pixels.pixel;
      s1_up  <= grey_mem[up_row][col_cur];
      s1_up2 <= grey_mem[up2_row][col_cur];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_pix  <= pixels.pixel;
      s1_gen  <= row_cur >= ROW_W'(1) && col_cur >= COL_W'(1);
      s1_gnz  <= row_cur >= ROW_W'(2) && col_cur >= COL_W'(2);
      s1_slot <= slot_prev;
      s1_col  <= col_cur - COL_W'(1);
    end
  end

  // stage 1: sobel over the current and two previous columns
  logic [GREY_W-1:0]        h1_pix, h1_up, h1_up2, h2_pix, h2_up, h2_up2;
  logic [GREY_W+1:0]        gx_right, gx_left, gy_bot, gy_top;
  logic signed [GRAD_W-1:0] gx_c, gy_c;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      h1_pix <= s1_pix;
      h1_up  <= s1_up;
      h1_up2 <= s1_up2;
      h2_pix <= h1_pix;
      h2_up  <= h1_up;
      h2_up2 <= h1_up2;
    end
  end

  always_comb begin
    gx_right = (GREY_W+2)'(s1_up2) + (GREY_W+2)'({s1_up, 1'b0}) + (GREY_W+2)'(s1_pix);
    gx_left  = (GREY_W+2)'(h2_up2) + (GREY_W+2)'({h2_up, 1'b0}) + (GREY_W+2)'(h2_pix);
    gy_bot   = (GREY_W+2)'(h2_pix) + (GREY_W+2)'({h1_pix, 1'b0}) + (GREY_W+2)'(s1_pix);
    gy_top   = (GREY_W+2)'(h2_up2) + (GREY_W+2)'({h1_up2, 1'b0}) + (GREY_W+2)'(s1_up2);
    if (s1_gnz) begin
      gx_c = $signed({1'b0, gx_right}) - $signed({1'b0, gx_left});
      gy_c = $signed({1'b0, gy_bot}) - $signed({1'b0, gy_top});
    end else begin
      gx_c = '0;
      gy_c = '0;
    end
  end

  // stage 2: gradient products
  logic signed [GRAD_W-1:0]   s2_gx, s2_gy;
  logic                       s2_gen;
  logic [SLOT_W-1:0]          s2_slot;
  logic [COL_W-1:0]           s2_col;
  logic signed [2*GRAD_W-1:0] pxx, pyy, pxy;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s2_gx   <= gx_c;
      s2_gy   <= gy_c;
      s2_gen  <= s1_gen;
      s2_slot <= s1_slot;
      s2_col  <= s1_col;
    end
  end

  assign pxx = s2_gx * s2_gx;
  assign pyy = s2_gy * s2_gy;
  assign pxy = s2_gx * s2_gy;

  // stage 3: column words, one slot per row of the window
  logic [SPAN-1:0][SQ_W-1:0]    xx_mem [MAX_WIDTH];
  logic [SPAN-1:0][SQ_W-1:0]    yy_mem [MAX_WIDTH];
  logic [SPAN-1:0][CROSS_W-1:0] xy_mem [MAX_WIDTH];
  logic [SPAN-1:0][SQ_W-1:0]    s3_wxx, s3_wyy, nw_xx, nw_yy;
  logic [SPAN-1:0][CROSS_W-1:0] s3_wxy, nw_xy;
  logic [SQ_W-1:0]              s3_xx, s3_yy;
  logic [CROSS_W-1:0]           s3_xy;
  logic                         s3_gen;
  logic [SLOT_W-1:0]            s3_slot;
  logic [COL_W-1:0]             s3_col;
  logic [CS_W-1:0]              cs_xx_c, cs_yy_c;
  logic signed [CS_W:0]         cs_xy_c;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s3_wxx <= xx_mem[s2_col];
      s3_wyy <= yy_mem[s2_col];
      s3_wxy <= xy_mem[s2_col];
    end
    if (adv[3] && s3_gen) begin
      xx_mem[s3_col] <= nw_xx;
      yy_mem[s3_col] <= nw_yy;
      xy_mem[s3_col] <= nw_xy;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s3_xx   <= pxx[SQ_W-1:0];
      s3_yy   <= pyy[SQ_W-1:0];
      s3_xy   <= pxy[CROSS_W-1:0];
      s3_gen  <= s2_gen;
      s3_slot <= s2_slot;
      s3_col  <= s2_col;
    end
  end

  always_comb begin
    nw_xx = s3_wxx;
    nw_yy = s3_wyy;
    nw_xy = s3_wxy;
    nw_xx[s3_slot] = s3_xx;
    nw_yy[s3_slot] = s3_yy;
    nw_xy[s3_slot] = s3_xy;
    cs_xx_c = '0;
    cs_yy_c = '0;
    cs_xy_c = '0;
    for (int i = 0; i < SPAN; i++) begin
      cs_xx_c = cs_xx_c + CS_W'(nw_xx[i]);
      cs_yy_c = cs_yy_c + CS_W'(nw_yy[i]);
      cs_xy_c = cs_xy_c + (CS_W+1)'($signed(nw_xy[i]));
    end
  end

  // stage 4: last SPAN column sums
  logic [CS_W-1:0]       cs_xx [SPAN];
  logic [CS_W-1:0]       cs_yy [SPAN];
  logic signed [CS_W:0]  cs_xy [SPAN];
  logic [WIN_W-1:0]      ws_xx, ws_yy;
  logic signed [WIN_W:0] ws_xy;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      cs_xx[0] <= cs_xx_c;
      cs_yy[0] <= cs_yy_c;
      cs_xy[0] <= cs_xy_c;
      for (int i = 1; i < SPAN; i++) begin
        cs_xx[i] <= cs_xx[i-1];
        cs_yy[i] <= cs_yy[i-1];
        cs_xy[i] <= cs_xy[i-1];
      end
    end
  end

  always_comb begin
    ws_xx = '0;
    ws_yy = '0;
    ws_xy = '0;
    for (int i = 0; i < SPAN; i++) begin
      ws_xx = ws_xx + WIN_W'(cs_xx[i]);
      ws_yy = ws_yy + WIN_W'(cs_yy[i]);
      ws_xy = ws_xy + (WIN_W+1)'(cs_xy[i]);
    end
  end

  // stage 5: det products and trace
  logic [WIN_W-1:0]            s5_sxx, s5_syy;
  logic signed [WIN_W:0]       s5_sxy;
  logic [PROD_W-1:0]           pa_c;
  logic signed [2*WIN_W+1:0]   pb_full;
  logic [TR_W-1:0]             tr_c;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s5_sxx <= ws_xx;
      s5_syy <= ws_yy;
      s5_sxy <= ws_xy;
    end
  end

  assign pa_c    = s5_sxx * s5_syy;
  assign pb_full = s5_sxy * s5_sxy;
  assign tr_c    = TR_W'(s5_sxx) + TR_W'(s5_syy);

  // stage 6: det and trace squared
  logic [PROD_W-1:0]        s6_pa, s6_pb;
  logic [TR_W-1:0]          s6_tr;
  logic signed [DET_W-1:0]  det_c;
  logic [T2_W-1:0]          t2_c;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s6_pa <= pa_c;
      s6_pb <= pb_full[PROD_W-1:0];
      s6_tr <= tr_c;
    end
  end

  assign det_c = $signed({1'b0, s6_pa}) - $signed({1'b0, s6_pb});
  assign t2_c  = s6_tr * s6_tr;

  // stage 7: k times trace squared, split at the fraction point
  logic signed [DET_W-1:0]  s7_det;
  logic [T2_W-1:0]          s7_t2;
  logic [HI_W-1:0]          hi_c;
  logic [K_W+FRAC_W-1:0]    lo_c;

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      s7_det <= det_c;
      s7_t2  <= t2_c;
    end
  end

  assign hi_c = harris_k * s7_t2[T2_W-1:FRAC_W];
  assign lo_c = harris_k * s7_t2[FRAC_W-1:0];

  // stage 8: combine the partial products
  logic signed [DET_W-1:0]  s8_det;
  logic [HI_W-1:0]          s8_hi;
  logic [K_W-1:0]           s8_lo;
  logic [KT_W-1:0]          kt_c;

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      s8_det <= s7_det;
      s8_hi  <= hi_c;
      s8_lo  <= lo_c[K_W+FRAC_W-1:FRAC_W];
    end
  end

  assign kt_c = KT_W'(s8_hi) + KT_W'(s8_lo);

  // stage 9: response
  logic signed [DET_W-1:0]  s9_det;
  logic [KT_W-1:0]          s9_kt;
  logic signed [RESP_W-1:0] resp_c;

  always_ff @(posedge clk) begin
    if (adv[8]) begin
      s9_det <= s8_det;
      s9_kt  <= kt_c;
    end
  end

  assign resp_c = RESP_W'(s9_det) - $signed({1'b0, s9_kt});

  // stage 10: threshold compare
  logic signed [RESP_W-1:0] s10_resp;
  logic                     hit;

  always_ff @(posedge clk) begin
    if (adv[9]) begin
      s10_resp <= resp_c;
    end
  end

  assign hit = $signed(CMP_W'(s10_resp)) >= $signed(CMP_W'(response_threshold));

  // output register
  logic out_corner, out_cvalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (rdy[NS+1]) begin
      out_v <= v[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[NS]) begin
      out_corner <= fl[NS].in_core && hit;
      out_cvalid <= fl[NS].centre_valid;
    end
  end

  assign results.valid        = out_v;
  assign results.corner       = out_corner;
  assign results.centre_valid = out_cvalid;

  `HCD_ASSERT_SAME(a_corner_in_image, results.valid && results.corner, results.centre_valid, "corner flagged for a centre outside the image")
  `HCD_ASSERT_SAME(a_column_rmw_apart, adv[2] && adv[3] && s2_gen && s3_gen, s2_col != s3_col, "column word read while the same column is written")
  `HCD_ASSERT_NEXT(a_last_stage_holds, v[NS] && !rdy[NS+1], v[NS] && $stable(fl[NS]), "last stage lost its item during a stall")
  `HCD_ASSERT_NEXT(a_transfer_enters, adv[0], v[1], "pixel transfer did not reach the first stage")

endmodule

`default_nettype wire
